[design/itpc_pkg.sv]
`default_nettype none

package itpc_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_POW   = 8'h5E;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_OPEN  = 3'd1,
      OP_PLUS  = 3'd2,
      OP_MINUS = 3'd3,
      OP_MUL   = 3'd4,
      OP_DIV   = 3'd5,
      OP_POW   = 3'd6
   } op_code_type;

   typedef enum logic [2:0] {
      ST_SYMBOL     = 3'd0,
      ST_DONE       = 3'd1,
      ST_UNBALANCED = 3'd2,
      ST_OVERFLOW   = 3'd3,
      ST_INVALID    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CLS_LETTER,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_OPERATOR,
      CLS_INVALID
   } class_type;

   typedef enum logic [1:0] {
      SRC_INPUT,
      SRC_TOP,
      SRC_DONE,
      SRC_ERROR
   } emit_src_type;

   typedef struct packed {
      logic         capture;
      logic         emit;
      emit_src_type src;
      logic         pop;
      logic         push;
      logic         clear;
      logic         err_load;
      status_type   err_code;
      logic         disc_load;
      logic         disc_clear;
   } cmd_type;

   typedef struct packed {
      logic      discarding;
      logic      last;
      class_type cls;
      logic      count_zero;
      logic      count_full;
      logic      top_open;
      logic      top_ge;
      logic      out_free;
   } stat_type;

   function automatic logic [1:0] prec_of(input logic [2:0] code);
      logic [1:0] p;
      case (code)
         OP_PLUS, OP_MINUS: p = 2'd1;
         OP_MUL, OP_DIV:    p = 2'd2;
         OP_POW:            p = 2'd3;
         default:           p = 2'd0;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] char_of(input logic [2:0] code);
      logic [7:0] c;
      case (code)
         OP_OPEN:  c = CH_OPEN;
         OP_PLUS:  c = CH_PLUS;
         OP_MINUS: c = CH_MINUS;
         OP_MUL:   c = CH_MUL;
         OP_DIV:   c = CH_DIV;
         OP_POW:   c = CH_POW;
         default:  c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[design/itpc_datapath.sv]
`default_nettype none

module itpc_datapath import itpc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast
);

   logic [2:0]       stack_ff [STACK_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             disc_ff, disc_in;
   logic [7:0]       ch_ff;
   logic             last_ff;
   status_type       err_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_sym_ff;
   status_type       rsp_status_ff;
   logic             rsp_last_ff;

   logic [CNT_W-1:0] count_m1;
   logic [IDX_W-1:0] top_idx;
   logic [IDX_W-1:0] push_idx;
   logic [2:0]       top_code;
   op_code_type      in_code;
   class_type        cls;
   logic             out_free;

   assign count_m1 = count_ff - CNT_W'(1);
   assign top_idx  = count_m1[IDX_W-1:0];
   assign push_idx = count_ff[IDX_W-1:0];
   assign top_code = stack_ff[top_idx];

   always_comb begin
      case (ch_ff)
         CH_OPEN:  in_code = OP_OPEN;
         CH_PLUS:  in_code = OP_PLUS;
         CH_MINUS: in_code = OP_MINUS;
         CH_MUL:   in_code = OP_MUL;
         CH_DIV:   in_code = OP_DIV;
         CH_POW:   in_code = OP_POW;
         default:  in_code = OP_NONE;
      endcase
      if (ch_ff inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]}) begin
         cls = CLS_LETTER;
      end else if (ch_ff == CH_CLOSE) begin
         cls = CLS_CLOSE;
      end else if (in_code == OP_OPEN) begin
         cls = CLS_OPEN;
      end else if (in_code != OP_NONE) begin
         cls = CLS_OPERATOR;
      end else begin
         cls = CLS_INVALID;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      stat.discarding = disc_ff;
      stat.last       = last_ff;
      stat.cls        = cls;
      stat.count_zero = (count_ff == '0);
      stat.count_full = (count_ff == CNT_W'(STACK_DEPTH));
      stat.top_open   = (top_code == OP_OPEN);
      stat.top_ge     = (prec_of(top_code) >= prec_of(in_code));
      stat.out_free   = out_free;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.pop) begin
         count_in = count_m1;
      end else if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end
      disc_in = disc_ff;
      if (cmd.disc_clear) begin
         disc_in = 1'b0;
      end else if (cmd.disc_load) begin
         disc_in = !last_ff;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         disc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         disc_ff      <= disc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stack entries are only read below the count, so they need no reset.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_ff[push_idx] <= in_code;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff   <= req_tdata;
         last_ff <= req_tlast;
      end
      if (cmd.err_load) begin
         err_ff <= cmd.err_code;
      end
      if (cmd.emit) begin
         case (cmd.src)
            SRC_INPUT: begin
               rsp_sym_ff    <= ch_ff;
               rsp_status_ff <= ST_SYMBOL;
               rsp_last_ff   <= 1'b0;
            end
            SRC_TOP: begin
               rsp_sym_ff    <= char_of(top_code);
               rsp_status_ff <= ST_SYMBOL;
               rsp_last_ff   <= 1'b0;
            end
            SRC_DONE: begin
               rsp_sym_ff    <= 8'h00;
               rsp_status_ff <= ST_DONE;
               rsp_last_ff   <= 1'b1;
            end
            default: begin
               rsp_sym_ff    <= 8'h00;
               rsp_status_ff <= err_ff;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_status_ff, rsp_sym_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[design/itpc_ctrl.sv]
`default_nettype none

module itpc_ctrl import itpc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CLOSE,
      S_POP,
      S_PUSH,
      S_FLUSH,
      S_ERROR
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.src  = SRC_INPUT;
      cmd.err_code = ST_SYMBOL;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.discarding) begin
               if (stat.last) begin
                  cmd.disc_clear = 1'b1;
                  cmd.clear      = 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               case (stat.cls)
                  CLS_LETTER: begin
                     if (stat.out_free) begin
                        cmd.emit = 1'b1;
                        state_in = stat.last ? S_FLUSH : S_IDLE;
                     end
                  end
                  CLS_CLOSE:    state_in = S_CLOSE;
                  CLS_OPERATOR: state_in = S_POP;
                  CLS_OPEN:     state_in = S_PUSH;
                  default: begin
                     cmd.err_load = 1'b1;
                     cmd.err_code = ST_INVALID;
                     state_in     = S_ERROR;
                  end
               endcase
            end
         end
         S_CLOSE: begin
            if (stat.count_zero) begin
               cmd.err_load = 1'b1;
               cmd.err_code = ST_UNBALANCED;
               state_in     = S_ERROR;
            end else if (stat.top_open) begin
               cmd.pop  = 1'b1;
               state_in = stat.last ? S_FLUSH : S_IDLE;
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_TOP;
               cmd.pop  = 1'b1;
            end
         end
         S_POP: begin
            if (!stat.count_zero && stat.top_ge) begin
               if (stat.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.src  = SRC_TOP;
                  cmd.pop  = 1'b1;
               end
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (stat.count_full) begin
               cmd.err_load = 1'b1;
               cmd.err_code = ST_OVERFLOW;
               state_in     = S_ERROR;
            end else begin
               cmd.push = 1'b1;
               state_in = stat.last ? S_FLUSH : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (stat.count_zero) begin
               if (stat.out_free) begin
                  cmd.emit  = 1'b1;
                  cmd.src   = SRC_DONE;
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end
            end else if (stat.top_open) begin
               cmd.err_load = 1'b1;
               cmd.err_code = ST_UNBALANCED;
               state_in     = S_ERROR;
            end else if (stat.out_free) begin
               cmd.emit = 1'b1;
               cmd.src  = SRC_TOP;
               cmd.pop  = 1'b1;
            end
         end
         S_ERROR: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.src       = SRC_ERROR;
               cmd.clear     = 1'b1;
               cmd.disc_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/infix_to_postfix_converter_unit.sv]
`default_nettype none

// Infix to postfix converter using an operator stack (shunting-yard).
// The req channel takes one ASCII character per beat, with req_tlast on the
// final character of an expression. The rsp channel returns postfix
// characters (status 0), then one closing beat, the only one with rsp_tlast
// high: status 1 on success, 2 for unbalanced parentheses, 3 for stack
// overflow, 4 for an invalid character. After an error the rest of the
// expression is dropped up to its last character.
// Each character is captured in the idle state and then decoded. A letter
// is copied from the capture register into the rsp output register. A '('
// goes through the push state to reach the stack, and a ')' pops entries
// up to and including its '('. An operator first pops and emits every entry
// of equal or higher precedence, then is pushed; after the final character
// the stack is flushed and the closing beat is sent. The stack is a single-read
// register file, one pop a cycle; a pop that emits waits for a free output.
// Reset empties the stack and clears the output valid flag; no clearing pass.
// When rsp_tready is low, the held beat stays in the output register and the
// controller waits before writing the next result; req_tready stays low
// until the current character is finished.
module infix_to_postfix_converter_unit import itpc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] symbol
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] out_symbol, [10:8] status, rest zero
   output logic             rsp_tlast
);

   cmd_type  cmd;
   stat_type stat;

   itpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   itpc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
